>>> hw/rtl/tnft_pkg.sv
// ----------------------------------------------------------------------------
// tnft_pkg
// Shared types and constants of the TCP NAT flow state tracker.
// ----------------------------------------------------------------------------
package tnft_pkg;

    localparam int FLOW_SLOTS_DEFAULT = 1024;
    localparam int SLOT_IN_W          = 10;
    localparam int SLOT_EXT_W         = 17;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [3:0] FS_SYN           = 4'd0;
    localparam logic [3:0] FS_SYNACK        = 4'd1;
    localparam logic [3:0] FS_EST           = 4'd2;
    localparam logic [3:0] FS_IN_FIN        = 4'd3;
    localparam logic [3:0] FS_OUT_FIN       = 4'd4;
    localparam logic [3:0] FS_WAIT_IN_FIN2  = 4'd5;
    localparam logic [3:0] FS_IN_FIN2       = 4'd6;
    localparam logic [3:0] FS_WAIT_OUT_FIN2 = 4'd7;
    localparam logic [3:0] FS_OUT_FIN2      = 4'd8;
    localparam logic [3:0] FS_CLOSED        = 4'd9;
    localparam logic [3:0] FS_RESET         = 4'd10;

    localparam logic [1:0] ACT_OPEN    = 2'd0;
    localparam logic [1:0] ACT_INSIDE  = 2'd1;
    localparam logic [1:0] ACT_OUTSIDE = 2'd2;

    typedef enum logic [2:0] {
        OP_OPEN   = 3'd0,
        OP_IN     = 3'd1,
        OP_OUT    = 3'd2,
        OP_BAD    = 3'd3,
        OP_NOSLOT = 3'd4
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [SLOT_IN_W-1:0] slot;
        logic                 syn;
        logic                 ack;
        logic                 fin;
        logic                 rst;
        logic                 match;
    } cmd_t;

endpackage

>>> hw/rtl/tnft_ram.sv
// ----------------------------------------------------------------------------
// tnft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tnft_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tnft_queue.sv
// ----------------------------------------------------------------------------
// tnft_queue
// Short command queue between the classifier and the flow update engine.
// ----------------------------------------------------------------------------
module tnft_queue
    import tnft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue pop while empty");

endmodule

>>> hw/rtl/tnft_front.sv
// ----------------------------------------------------------------------------
// tnft_front
// Accepts transactions and classifies them into update commands.
// ----------------------------------------------------------------------------
module tnft_front
    import tnft_pkg::*;
#(
    parameter int FLOW_SLOTS = FLOW_SLOTS_DEFAULT
) (
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           action,
    input  logic [SLOT_IN_W-1:0] flow_slot,
    input  logic                 syn,
    input  logic                 ack,
    input  logic                 fin,
    input  logic                 rst_req,
    input  logic                 endpoint_match,
    input  logic                 clearing,
    input  logic                 queue_full,
    output logic                 push,
    output cmd_t                 push_cmd
);

    logic [SLOT_EXT_W-1:0] slot_ext;
    logic                  in_range;

    assign slot_ext = {{(SLOT_EXT_W-SLOT_IN_W){1'b0}}, flow_slot};
    assign in_range = (slot_ext < SLOT_EXT_W'(FLOW_SLOTS));
    assign busy     = clearing || queue_full;
    assign push     = start && !busy;

    always_comb
    begin
        push_cmd.slot  = flow_slot;
        push_cmd.syn   = syn;
        push_cmd.ack   = ack;
        push_cmd.fin   = fin;
        push_cmd.rst   = rst_req;
        push_cmd.match = endpoint_match;
        if (!in_range)
        begin
            push_cmd.op = OP_NOSLOT;
        end
        else
        begin
            unique case (action)
                ACT_OPEN:    push_cmd.op = OP_OPEN;
                ACT_INSIDE:  push_cmd.op = OP_IN;
                ACT_OUTSIDE: push_cmd.op = OP_OUT;
                default:     push_cmd.op = OP_BAD;
            endcase
        end
    end

endmodule

>>> hw/rtl/tnft_back.sv
// ----------------------------------------------------------------------------
// tnft_back
// Flow update engine: read-modify-write of the slot valid and state RAMs.
// ----------------------------------------------------------------------------
module tnft_back
    import tnft_pkg::*;
#(
    parameter int FLOW_SLOTS = FLOW_SLOTS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       queue_empty,
    input  cmd_t       head_cmd,
    output logic       pop,
    output logic       clearing,
    output logic       done,
    output logic       verdict,
    output logic [3:0] new_state
);

    localparam int SLOT_W = $clog2(FLOW_SLOTS);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [SLOT_W-1:0]     clr_cnt_reg;
    logic [SLOT_W-1:0]     clr_cnt_next;
    cmd_t                  cmd_reg;
    logic                  done_reg;
    logic                  verdict_reg;
    logic [3:0]            new_state_reg;

    logic [SLOT_EXT_W-1:0] head_ext;
    logic [SLOT_EXT_W-1:0] cmd_ext;
    logic [SLOT_W-1:0]     raddr;
    logic [SLOT_W-1:0]     waddr;
    logic                  valid_rd;
    logic [3:0]            state_rd;
    logic                  valid_we;
    logic                  valid_wdata;
    logic                  state_we;
    logic [3:0]            state_wdata;

    logic                  slot_on;
    logic [3:0]            cur;
    logic [3:0]            nxt;
    logic                  res_drop;
    logic [3:0]            res_state;
    logic                  upd_valid;
    logic                  upd_state;

    assign head_ext = {{(SLOT_EXT_W-SLOT_IN_W){1'b0}}, head_cmd.slot};
    assign cmd_ext  = {{(SLOT_EXT_W-SLOT_IN_W){1'b0}}, cmd_reg.slot};
    assign raddr    = head_ext[SLOT_W-1:0];
    assign clearing = (state_reg == ST_CLEAR);
    assign pop      = (state_reg == ST_IDLE) && !queue_empty;

    always_comb
    begin
        slot_on   = (cmd_reg.op != OP_NOSLOT) && valid_rd;
        cur       = slot_on ? state_rd : FS_SYN;
        nxt       = cmd_reg.rst ? FS_RESET : cur;
        res_drop  = 1'b1;
        res_state = cur;
        upd_valid = 1'b0;
        upd_state = 1'b0;
        case (cmd_reg.op) inside
            OP_OPEN, OP_IN:
            begin
                if (!slot_on)
                begin
                    res_state = FS_SYN;
                    if ((cmd_reg.op == OP_OPEN) && cmd_reg.syn)
                    begin
                        res_drop  = 1'b0;
                        upd_valid = 1'b1;
                        upd_state = 1'b1;
                    end
                end
                else if (!((cur == FS_CLOSED) || (cur == FS_RESET)))
                begin
                    if (cmd_reg.fin)
                    begin
                        nxt = (nxt == FS_WAIT_IN_FIN2) ? FS_IN_FIN2 : FS_IN_FIN;
                    end
                    else if (cmd_reg.ack && (nxt == FS_OUT_FIN))
                    begin
                        nxt = FS_WAIT_IN_FIN2;
                    end
                    else if (cmd_reg.ack && (nxt == FS_OUT_FIN2))
                    begin
                        nxt = FS_CLOSED;
                    end
                    else if (cmd_reg.ack && (nxt == FS_SYNACK))
                    begin
                        nxt = FS_EST;
                    end
                    res_drop  = 1'b0;
                    res_state = nxt;
                    upd_state = 1'b1;
                end
            end
            OP_OUT:
            begin
                if (!slot_on)
                begin
                    res_state = FS_SYN;
                end
                else if (!((cur == FS_CLOSED) || (cur == FS_RESET)))
                begin
                    upd_state = 1'b1;
                    if (cmd_reg.fin)
                    begin
                        nxt = (nxt == FS_WAIT_OUT_FIN2) ? FS_OUT_FIN2 : FS_OUT_FIN;
                    end
                    else if (cmd_reg.ack && (nxt == FS_IN_FIN))
                    begin
                        nxt = FS_WAIT_OUT_FIN2;
                    end
                    else if (cmd_reg.ack && (nxt == FS_IN_FIN2))
                    begin
                        nxt = FS_CLOSED;
                    end
                    else if (nxt == FS_SYN)
                    begin
                        if (cmd_reg.syn && cmd_reg.ack)
                        begin
                            nxt = FS_SYNACK;
                        end
                        else
                        begin
                            upd_state = 1'b0;
                        end
                    end
                    res_state = nxt;
                    res_drop  = !(upd_state && cmd_reg.match);
                end
            end
            default:
            begin
                res_drop  = 1'b1;
                res_state = cur;
            end
        endcase
    end

    always_comb
    begin
        valid_we    = 1'b0;
        valid_wdata = 1'b0;
        state_we    = 1'b0;
        state_wdata = res_state;
        waddr       = cmd_ext[SLOT_W-1:0];
        if (state_reg == ST_CLEAR)
        begin
            valid_we = 1'b1;
            waddr    = clr_cnt_reg;
        end
        else if (state_reg == ST_EXEC)
        begin
            valid_we    = upd_valid;
            valid_wdata = 1'b1;
            state_we    = upd_state;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SLOT_W'(FLOW_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= (state_reg == ST_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head_cmd;
        end
        if (state_reg == ST_EXEC)
        begin
            verdict_reg   <= res_drop;
            new_state_reg <= res_state;
        end
    end

    tnft_ram #(
        .WIDTH (1),
        .DEPTH (FLOW_SLOTS)
    ) u_valid_ram (
        .clk   (clk),
        .we    (valid_we),
        .waddr (waddr),
        .wdata (valid_wdata),
        .raddr (raddr),
        .rdata (valid_rd)
    );

    tnft_ram #(
        .WIDTH (4),
        .DEPTH (FLOW_SLOTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (state_we),
        .waddr (waddr),
        .wdata (state_wdata),
        .raddr (raddr),
        .rdata (state_rd)
    );

    assign done      = done_reg;
    assign verdict   = verdict_reg;
    assign new_state = new_state_reg;

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> done_reg)
        else $error("update did not produce a result");

    a_done_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_EXEC))
        else $error("result without an update");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !pop && !state_we)
        else $error("command taken during clear sweep");

    a_noslot_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (cmd_reg.op == OP_NOSLOT)) |-> (verdict_reg && (new_state_reg == FS_SYN)))
        else $error("out-of-range slot not dropped");

endmodule

>>> hw/rtl/tcp_nat_flow_state_tracker.sv
// ----------------------------------------------------------------------------
// tcp_nat_flow_state_tracker
// Per-flow TCP state tracking for NAT with forward/drop verdicts.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Each one yields
// one result, shown for a single cycle with done high; the result comes later
// when the transaction waits in the queue behind earlier transactions. The
// receiver cannot stall, so results are never held back. The update engine
// works on one transaction at a time (a registered read of the slot's valid
// and state RAMs, then the update and write back) and takes no new one until
// it is done; a two-entry queue lets short bursts be taken at one per cycle
// while it is not full. After reset, busy stays high while the valid RAM is
// cleared one slot per cycle.
module tcp_nat_flow_state_tracker
    import tnft_pkg::*;
#(
    parameter int FLOW_SLOTS = FLOW_SLOTS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           action,
    input  logic [SLOT_IN_W-1:0] flow_slot,
    input  logic                 syn,
    input  logic                 ack,
    input  logic                 fin,
    input  logic                 rst_req,
    input  logic                 endpoint_match,
    output logic                 done,
    output logic                 verdict,
    output logic [3:0]           new_state
);

    logic clearing;
    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    tnft_front #(
        .FLOW_SLOTS (FLOW_SLOTS)
    ) u_front (
        .start          (start),
        .busy           (busy),
        .action         (action),
        .flow_slot      (flow_slot),
        .syn            (syn),
        .ack            (ack),
        .fin            (fin),
        .rst_req        (rst_req),
        .endpoint_match (endpoint_match),
        .clearing       (clearing),
        .queue_full     (queue_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    tnft_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    tnft_back #(
        .FLOW_SLOTS (FLOW_SLOTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .clearing    (clearing),
        .done        (done),
        .verdict     (verdict),
        .new_state   (new_state)
    );

endmodule
